// ===== rtl/cbt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared sizes, command and result codes, and types for the callback timer
// table.
// ----------------------------------------------------------------------------
package cbt_pkg;

   localparam int SLOTS      = 16;
   localparam int LEVELS     = 4;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CTX_IDX_W  = $clog2(LEVELS + 1);

   localparam int CMD_W  = 3;
   localparam int ID_W   = 8;
   localparam int TIME_W = 32;
   localparam int CTX_W  = 3;

   localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REGISTER    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CHANGE      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_DELAY   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SET_TIMEOUT = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd5;

   localparam logic [1:0] KIND_FIRED  = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_BUSY = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic signed [TIME_W-1:0] count;
   } slot_type;

   typedef struct packed {
      logic              tick;
      logic              set_delay;
      logic              set_timeout;
      logic [CTX_W-1:0]  ctx;
      logic [TIME_W-1:0] value;
   } cnt_req_type;

   typedef struct packed {
      logic delay_pending;
      logic timeout_expired;
      logic thread_busy;
   } cnt_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/cbt_counters.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_counters
// Delay and timeout counters for thread context and each ISR level, with
// tick decrement, loads and a query view of one context.
// ----------------------------------------------------------------------------
module cbt_counters
   import cbt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cnt_req_type req,
   output cnt_rsp_type      rsp
);

   // entry 0 is thread context, entry n is ISR level n-1
   logic [TIME_W-1:0] delay_ff   [0:LEVELS];
   logic [TIME_W-1:0] delay_in   [0:LEVELS];
   logic [TIME_W-1:0] timeout_ff [0:LEVELS];
   logic [TIME_W-1:0] timeout_in [0:LEVELS];

   logic [7:0]           ctx_w;
   logic                 ctx_ok;
   logic [CTX_IDX_W-1:0] sel;

   assign ctx_w  = 8'(req.ctx);
   assign ctx_ok = ctx_w <= 8'(LEVELS);
   assign sel    = ctx_ok ? ctx_w[CTX_IDX_W-1:0] : '0;

   always_comb begin
      for (int i = 0; i <= LEVELS; i++) begin
         delay_in[i]   = delay_ff[i];
         timeout_in[i] = timeout_ff[i];
         if (req.tick) begin
            if (delay_ff[i] != '0) delay_in[i] = delay_ff[i] - TIME_W'(1);
            if (timeout_ff[i] != '0) timeout_in[i] = timeout_ff[i] - TIME_W'(1);
         end
         // thread delay loads only when it has run out
         if (req.set_delay && ctx_ok && sel == CTX_IDX_W'(i)
             && !(i == 0 && delay_ff[0] != '0)) begin
            delay_in[i] = req.value;
         end
         if (req.set_timeout && ctx_ok && sel == CTX_IDX_W'(i)) begin
            timeout_in[i] = req.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LEVELS; i++) begin
            delay_ff[i]   <= '0;
            timeout_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i <= LEVELS; i++) begin
            delay_ff[i]   <= delay_in[i];
            timeout_ff[i] <= timeout_in[i];
         end
      end
   end

   assign rsp.delay_pending   = ctx_ok && (delay_ff[sel] != '0);
   assign rsp.timeout_expired = !ctx_ok || (timeout_ff[sel] == '0);
   assign rsp.thread_busy     = delay_ff[0] != '0;

endmodule
`default_nettype wire

// ===== rtl/callback_timer_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// callback_timer_table_top
// Table of timed callback slots with delay and timeout counters per context.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Set delay, set
// timeout, query and unused commands finish in the cycle they are taken and
// answer in the next cycle, so a new request may follow at once. Tick, register
// and change walk the slot memory through its single read port, one slot a
// cycle, and hold busy through the walk: a read of each slot, its registered
// read data, and a flush state that closes the walk. A tick reports every
// slot that reaches zero in slot order; the walk holds back each fired slot
// until the next one or the end of the walk is seen, so the final report
// carries last. Register and change write their slot at the end of the walk.
// Results stand on the rsp_ ports for exactly one cycle, marked by rsp_valid;
// the receiver cannot stall them. The slot memory needs no clearing pass: a
// valid bit per slot, cleared by reset, makes an unwritten slot read as empty.
// ----------------------------------------------------------------------------
module callback_timer_table_top
   import cbt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [CMD_W-1:0]         req_command,
   input  wire logic [ID_W-1:0]          req_callback_id,
   input  wire logic signed [TIME_W-1:0] req_time_ms,
   input  wire logic [CTX_W-1:0]         req_context_req,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_result_kind,
   output logic [ID_W-1:0]               rsp_fired_id,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_delay_pending,
   output logic                          rsp_timeout_expired,
   output logic                          rsp_last
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(SLOTS - 1);

   // slot memory and its valid bits
   slot_type   slot_mem [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   slot_type   rd_data_ff;
   logic       rd_vld_ff;
   logic       wr_en;
   logic [SLOT_IDX_W-1:0] wr_idx;
   slot_type   wr_data;

   // control
   logic [1:0] state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic signed [TIME_W-1:0] time_ff, time_in;
   logic [SLOT_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic       iss_ff, iss_in;
   logic       pipe_vld_ff, pipe_vld_in;
   logic [SLOT_IDX_W-1:0] pipe_idx_ff, pipe_idx_in;
   logic       match_vld_ff, match_vld_in;
   logic [SLOT_IDX_W-1:0] match_idx_ff, match_idx_in;
   logic       free_vld_ff, free_vld_in;
   logic [SLOT_IDX_W-1:0] free_idx_ff, free_idx_in;
   logic       pend_vld_ff, pend_vld_in;
   logic [ID_W-1:0] pend_id_ff, pend_id_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_dp_ff, rsp_dp_in;
   logic       rsp_te_ff, rsp_te_in;
   logic       rsp_last_ff, rsp_last_in;

   cnt_req_type cnt_req;
   cnt_rsp_type cnt_rsp;
   slot_type    cur;
   logic        accept;
   logic        cur_pos;

   cbt_counters u_counters (
      .clock (clock),
      .reset (reset),
      .req   (cnt_req),
      .rsp   (cnt_rsp)
   );

   assign busy    = state_ff != ST_IDLE;
   assign accept  = start && !busy;
   // an unwritten slot reads as empty
   assign cur     = rd_vld_ff ? rd_data_ff : '0;
   assign cur_pos = !cur.count[TIME_W-1] && (cur.count != '0);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      time_in      = time_ff;
      rd_idx_in    = rd_idx_ff;
      iss_in       = iss_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = pipe_idx_ff;
      match_vld_in = match_vld_ff;
      match_idx_in = match_idx_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_id_in   = pend_id_ff;

      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_STATUS;
      rsp_id_in     = '0;
      rsp_status_in = STAT_OK;
      rsp_dp_in     = 1'b0;
      rsp_te_in     = 1'b0;
      rsp_last_in   = 1'b0;

      wr_en   = 1'b0;
      wr_idx  = pipe_idx_ff;
      wr_data = '0;

      cnt_req.tick        = 1'b0;
      cnt_req.set_delay   = 1'b0;
      cnt_req.set_timeout = 1'b0;
      cnt_req.ctx         = req_context_req;
      cnt_req.value       = req_time_ms;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               id_in   = req_callback_id;
               time_in = req_time_ms;
               case (req_command)
                  CMD_TICK, CMD_REGISTER, CMD_CHANGE: begin
                     // a tick steps the counters now; slots follow in the walk
                     cnt_req.tick = req_command == CMD_TICK;
                     state_in     = ST_WALK;
                     rd_idx_in    = '0;
                     iss_in       = 1'b1;
                     match_vld_in = 1'b0;
                     free_vld_in  = 1'b0;
                     pend_vld_in  = 1'b0;
                  end
                  CMD_SET_DELAY: begin
                     cnt_req.set_delay = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = (req_context_req == '0 && cnt_rsp.thread_busy)
                                     ? STAT_BUSY : STAT_OK;
                  end
                  CMD_SET_TIMEOUT: begin
                     cnt_req.set_timeout = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
                  CMD_QUERY: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_kind_in  = KIND_QUERY;
                     rsp_dp_in    = cnt_rsp.delay_pending;
                     rsp_te_in    = cnt_rsp.timeout_expired;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // issue side: advance the read address one slot a cycle
            if (iss_ff) begin
               pipe_vld_in = 1'b1;
               pipe_idx_in = rd_idx_ff;
               if (rd_idx_ff == LAST_SLOT) iss_in = 1'b0;
               else rd_idx_in = rd_idx_ff + SLOT_IDX_W'(1);
            end
            // process side: slot read in the previous cycle
            if (pipe_vld_ff) begin
               if (cmd_ff == CMD_TICK) begin
                  if (cur_pos) begin
                     wr_en         = 1'b1;
                     wr_data.id    = cur.id;
                     wr_data.count = cur.count - 32'sd1;
                     if (cur.count == 32'sd1) begin
                        // release the held report, hold this one
                        if (pend_vld_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = KIND_FIRED;
                           rsp_id_in    = pend_id_ff;
                        end
                        pend_vld_in = 1'b1;
                        pend_id_in  = cur.id;
                     end
                  end
               end else begin
                  if (cmd_ff == CMD_CHANGE && !match_vld_ff && cur.id == id_ff) begin
                     match_vld_in = 1'b1;
                     match_idx_in = pipe_idx_ff;
                  end
                  if (!free_vld_ff && cur.count == '0) begin
                     free_vld_in = 1'b1;
                     free_idx_in = pipe_idx_ff;
                  end
               end
               if (pipe_idx_ff == LAST_SLOT) state_in = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            state_in = ST_IDLE;
            if (cmd_ff == CMD_TICK) begin
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_FIRED;
                  rsp_id_in    = pend_id_ff;
                  rsp_last_in  = 1'b1;
               end
               pend_vld_in = 1'b0;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               wr_data.id    = id_ff;
               wr_data.count = time_ff;
               if (match_vld_ff) begin
                  wr_en  = 1'b1;
                  wr_idx = match_idx_ff;
               end else if (free_vld_ff) begin
                  wr_en  = 1'b1;
                  wr_idx = free_idx_ff;
               end else begin
                  rsp_status_in = STAT_FULL;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // slot memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[wr_idx] <= wr_data;
      rd_data_ff <= slot_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= valid_ff[rd_idx_ff];
         if (wr_en) valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= 1'b0;
         pipe_vld_ff  <= 1'b0;
         match_vld_ff <= 1'b0;
         free_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         pipe_vld_ff  <= pipe_vld_in;
         match_vld_ff <= match_vld_in;
         free_vld_ff  <= free_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      time_ff       <= time_in;
      rd_idx_ff     <= rd_idx_in;
      pipe_idx_ff   <= pipe_idx_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      pend_id_ff    <= pend_id_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dp_ff     <= rsp_dp_in;
      rsp_te_ff     <= rsp_te_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_fired_id        = rsp_id_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_delay_pending   = rsp_dp_ff;
   assign rsp_timeout_expired = rsp_te_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/cbt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbt_checker
// Port-level checks for the callback timer table, bound to the top level.
// ----------------------------------------------------------------------------
module cbt_checker
   import cbt_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic [CMD_W-1:0]         req_command,
   input wire logic                     rsp_valid,
   input wire logic [1:0]               rsp_result_kind,
   input wire logic [ID_W-1:0]          rsp_fired_id,
   input wire logic                     rsp_last
);

   logic quick_cmd;
   assign quick_cmd = start && !busy && req_command != CMD_TICK
                      && req_command != CMD_REGISTER && req_command != CMD_CHANGE;

   // single-result commands answer in the next cycle, marked last
   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      quick_cmd |=> rsp_valid && rsp_last)
      else $error("single-result command did not answer next cycle");

   // a query answers with a query result
   a_query_kind: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_QUERY) |=> rsp_result_kind == KIND_QUERY)
      else $error("query answered with wrong kind");

   // walking commands hold off further requests
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_TICK || req_command == CMD_REGISTER
                          || req_command == CMD_CHANGE)) |=> busy)
      else $error("walk did not raise busy");

   // status and query results are always final and carry no fired id
   a_non_fired: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind != KIND_FIRED) |-> rsp_last && rsp_fired_id == '0)
      else $error("non-fired result malformed");

   // a final result is never followed by more results of the same request
   a_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !busy && !start) |=> !rsp_valid)
      else $error("result after last with no new request");

endmodule

bind callback_timer_table_top cbt_checker u_cbt_checker (.*);
`default_nettype wire
